>>> rtl/tkss_pkg.sv
// Shared types and constants of the top-K similarity selector.
`timescale 1ns / 1ps

package tkss_pkg;

   // Size of the ranked hit list.
   localparam int TOP_K  = 8;
   localparam int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

   // Field widths.
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int SCORE_W = 40;
   localparam int INDEX_W = 16;
   localparam int HIT_RANK_W = 5;

   // Command queue between front and back.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Result queue at the output.
   localparam int OUTQ_DEPTH = 2;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // Input item function codes.
   localparam logic FUNC_ELEM = 1'b0;
   localparam logic FUNC_EOQ  = 1'b1;

   // Saturation bounds of the score.
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   // Command from the front: a finished candidate or an end of query.
   typedef struct packed {
      logic                      eoq;
      logic                      keep;
      logic signed [SCORE_W-1:0] score;
      logic [INDEX_W-1:0]        index;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic                      valid;
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] score;
      logic [HIT_RANK_W-1:0]     rank;
      logic                      last;
   } hit_type;

endpackage

>>> rtl/top_k_similarity_select.sv
// Top level of the top-K dot-product similarity selector.
`timescale 1ns / 1ps

// Usage:
//   Input channel (req_*): push an item when req_full is low. req_func low
//   carries one element pair of the current candidate; req_elem_last closes
//   the candidate, whose req_cand_index and req_len_match are sampled then.
//   req_func high ends the query and emits the ranked hits.
//   Result channel (rsp_*): a result waits while rsp_empty is low; rsp_pop
//   takes it. Hits come best first with rsp_hit_rank counting from 0, and
//   rsp_hit_last marks the final one. A query with no hits gives a single
//   result with rsp_hit_valid low.
//   Configuration (csr_*): csr_data sets the 40-bit score threshold; always
//   ready. Write it only while the block is idle.
// Throughput: one item per cycle while the back end keeps up. A product
//   stage, a saturating accumulator and a command register feed a 4-entry
//   command queue; the back end takes one command per cycle while idle,
//   inserting with parallel compares, but an end of query holds it until all
//   its results (n hits, or one empty result) are written. Meanwhile commands
//   wait, and req_full rises once the command queue and the two front stages
//   hold four items. An end of query passes the product stage, command register
//   and command queue; then one result per cycle, while a 2-entry queue has room.
// Reset: list empty, accumulator clear, threshold 0. A stalled receiver fills
//   the result and command queues in turn, then raises req_full; no item is lost.
module top_k_similarity_select (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_func,
   input  logic signed [tkss_pkg::ELEM_W-1:0]   req_cand_elem,
   input  logic signed [tkss_pkg::ELEM_W-1:0]   req_query_elem,
   input  logic                                 req_elem_last,
   input  logic [tkss_pkg::INDEX_W-1:0]         req_cand_index,
   input  logic                                 req_len_match,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_hit_valid,
   output logic [tkss_pkg::INDEX_W-1:0]         rsp_hit_index,
   output logic signed [tkss_pkg::SCORE_W-1:0]  rsp_hit_score,
   output logic [tkss_pkg::HIT_RANK_W-1:0]      rsp_hit_rank,
   output logic                                 rsp_hit_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic signed [tkss_pkg::SCORE_W-1:0]  csr_data
);
   import tkss_pkg::*;

   logic                  cmd_push;
   cmd_type               cmd_data;
   logic                  cmd_pop;
   cmd_type               cmd_head;
   logic                  cmd_empty;
   logic [CMDQ_CNT_W-1:0] cmd_count;
   hit_type               rsp_hit;

   // Front: accept items, accumulate, classify finished candidates.
   tkss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_cand_elem  (req_cand_elem),
      .req_query_elem (req_query_elem),
      .req_elem_last  (req_elem_last),
      .req_cand_index (req_cand_index),
      .req_len_match  (req_len_match),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .cmdq_count     (cmd_count),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data)
   );

   // Decouple the two halves so each can stall on its own.
   tkss_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // Back: rank the list and emit hits.
   tkss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_hit   (rsp_hit)
   );

   assign rsp_hit_valid = rsp_hit.valid;
   assign rsp_hit_index = rsp_hit.index;
   assign rsp_hit_score = rsp_hit.score;
   assign rsp_hit_rank  = rsp_hit.rank;
   assign rsp_hit_last  = rsp_hit.last;

endmodule

>>> rtl/tkss_cmd_queue.sv
// Command queue that decouples the accumulate front from the ranking back.
`timescale 1ns / 1ps

module tkss_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tkss_pkg::cmd_type         push_data,
   input  logic                      pop,
   output tkss_pkg::cmd_type         head,
   output logic                      empty,
   output logic [tkss_pkg::CMDQ_CNT_W-1:0] count
);
   import tkss_pkg::*;

   cmd_type               mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [CMDQ_PTR_W-1:0] ptr_next(input logic [CMDQ_PTR_W-1:0] p);
      if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (cnt_ff == '0);
   assign count = cnt_ff;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (cnt_ff != CMDQ_CNT_W'(CMDQ_DEPTH)))
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("command queue read while empty");
`endif

endmodule

>>> rtl/tkss_front.sv
// Front: multiply, saturating accumulate and classification into commands.
`timescale 1ns / 1ps

module tkss_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_func,
   input  logic signed [tkss_pkg::ELEM_W-1:0]     req_cand_elem,
   input  logic signed [tkss_pkg::ELEM_W-1:0]     req_query_elem,
   input  logic                                   req_elem_last,
   input  logic [tkss_pkg::INDEX_W-1:0]           req_cand_index,
   input  logic                                   req_len_match,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic signed [tkss_pkg::SCORE_W-1:0]    csr_data,
   input  logic [tkss_pkg::CMDQ_CNT_W-1:0]        cmdq_count,
   output logic                                   cmd_push,
   output tkss_pkg::cmd_type                      cmd_data
);
   import tkss_pkg::*;

   logic                      accept;
   logic [CMDQ_CNT_W:0]       pending;

   // Product stage.
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_eoq_ff;
   logic                      s1_last_ff;
   logic signed [PROD_W-1:0]  s1_prod_ff;
   logic [INDEX_W-1:0]        s1_index_ff;
   logic                      s1_len_ff;

   // Accumulate stage.
   logic signed [SCORE_W-1:0] acc_ff, acc_in;
   logic signed [SCORE_W:0]   sum;
   logic signed [SCORE_W-1:0] sum_sat;
   logic                      cmd_valid_ff, cmd_valid_in;
   logic                      cmd_eoq_ff, cmd_eoq_in;
   logic                      cmd_len_ff, cmd_len_in;
   logic signed [SCORE_W-1:0] cmd_score_ff, cmd_score_in;
   logic [INDEX_W-1:0]        cmd_index_ff, cmd_index_in;

   logic signed [SCORE_W-1:0] thr_ff, thr_in;

   // Hold off items unless every item in flight is sure of a queue slot.
   assign pending  = {1'b0, cmdq_count} + (CMDQ_CNT_W + 1)'(s1_valid_ff)
                   + (CMDQ_CNT_W + 1)'(cmd_valid_ff);
   assign req_full = (pending >= (CMDQ_CNT_W + 1)'(CMDQ_DEPTH));
   assign accept   = req_push && !req_full;
   assign csr_ready = 1'b1;

   assign s1_valid_in = accept;
   assign thr_in      = (csr_valid && csr_ready) ? csr_data : thr_ff;

   always_comb begin
      sum = {acc_ff[SCORE_W-1], acc_ff}
          + {{(SCORE_W + 1 - PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff};
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         sum_sat = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sum_sat = sum[SCORE_W-1:0];
      end

      acc_in       = acc_ff;
      cmd_valid_in = 1'b0;
      cmd_eoq_in   = s1_eoq_ff;
      cmd_len_in   = s1_len_ff;
      cmd_score_in = sum_sat;
      cmd_index_in = s1_index_ff;
      if (s1_valid_ff) begin
         if (s1_eoq_ff) begin
            acc_in       = '0;
            cmd_valid_in = 1'b1;
         end else if (s1_last_ff) begin
            acc_in       = '0;
            cmd_valid_in = 1'b1;
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   assign cmd_push       = cmd_valid_ff;
   assign cmd_data.eoq   = cmd_eoq_ff;
   assign cmd_data.keep  = cmd_len_ff && ($signed(cmd_score_ff) >= $signed(thr_ff));
   assign cmd_data.score = cmd_score_ff;
   assign cmd_data.index = cmd_index_ff;

   always_ff @(posedge clock) begin
      s1_eoq_ff    <= (req_func == FUNC_EOQ);
      s1_last_ff   <= req_elem_last;
      s1_prod_ff   <= req_cand_elem * req_query_elem;
      s1_index_ff  <= req_cand_index;
      s1_len_ff    <= req_len_match;
      cmd_eoq_ff   <= cmd_eoq_in;
      cmd_len_ff   <= cmd_len_in;
      cmd_score_ff <= cmd_score_in;
      cmd_index_ff <= cmd_index_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         cmd_valid_ff <= 1'b0;
         acc_ff       <= '0;
         thr_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         cmd_valid_ff <= cmd_valid_in;
         acc_ff       <= acc_in;
         thr_ff       <= thr_in;
      end
   end

`ifndef ASSERT_OFF
   a_acc_clear_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_eoq_ff || s1_last_ff)) |=> (acc_ff == '0))
      else $error("accumulator not cleared after a candidate ends");

   a_cmd_follows_stage: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff |-> $past(s1_valid_ff))
      else $error("command without an item in the product stage");
`endif

endmodule

>>> rtl/tkss_back.sv
// Back: sorted top-K list, insertion, and ranked emission into the result queue.
`timescale 1ns / 1ps

module tkss_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   input  tkss_pkg::cmd_type                   cmd_head,
   output logic                                cmd_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output tkss_pkg::hit_type                   rsp_hit
);
   import tkss_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;

   logic signed [SCORE_W-1:0] best_score_ff [TOP_K];
   logic signed [SCORE_W-1:0] best_score_in [TOP_K];
   logic [INDEX_W-1:0]        best_index_ff [TOP_K];
   logic [INDEX_W-1:0]        best_index_in [TOP_K];
   logic [TOP_K-1:0]          used_ff, used_in;

   hit_type                   outq_ff [OUTQ_DEPTH];
   hit_type                   outq_in [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]     outq_wr_ff, outq_wr_in;
   logic [OUTQ_PTR_W-1:0]     outq_rd_ff, outq_rd_in;
   logic [OUTQ_CNT_W-1:0]     outq_cnt_ff, outq_cnt_in;

   logic [TOP_K-1:0]          beats;
   logic [TOP_K-1:0]          beats_prev;
   logic [TOP_K-1:0]          used_after;
   logic                      do_insert;
   logic                      res_push;
   logic                      res_pop;
   hit_type                   res;

   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;
   assign do_insert = cmd_pop && !cmd_head.eoq && cmd_head.keep;
   assign res_push  = (state_ff == S_EMIT) && (outq_cnt_ff != OUTQ_CNT_W'(OUTQ_DEPTH));
   assign res_pop   = rsp_pop && (outq_cnt_ff != '0);
   assign rsp_empty = (outq_cnt_ff == '0);
   assign rsp_hit   = outq_ff[outq_rd_ff];

   // A free slot or a strictly lower score yields; the list is sorted so this is monotone.
   always_comb begin
      for (int k = 0; k < TOP_K; k++) begin
         beats[k] = !used_ff[k] || ($signed(cmd_head.score) > $signed(best_score_ff[k]));
      end
      beats_prev = beats << 1;
      used_after = used_ff >> 1;
   end

   always_comb begin
      res.valid = used_ff[rank_ff];
      res.index = used_ff[rank_ff] ? best_index_ff[rank_ff] : '0;
      res.score = used_ff[rank_ff] ? best_score_ff[rank_ff] : '0;
      res.rank  = HIT_RANK_W'(rank_ff);
      res.last  = !used_ff[rank_ff] || !used_after[rank_ff];
   end

   always_comb begin
      state_in      = state_ff;
      rank_in       = rank_ff;
      best_score_in = best_score_ff;
      best_index_in = best_index_ff;
      used_in       = used_ff;
      outq_in       = outq_ff;
      outq_wr_in    = outq_wr_ff;
      outq_rd_in    = outq_rd_ff;
      outq_cnt_in   = outq_cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop && cmd_head.eoq) begin
               state_in = S_EMIT;
               rank_in  = '0;
            end
         end
         S_EMIT: begin
            if (res_push) begin
               if (res.last) begin
                  state_in = S_IDLE;
                  used_in  = '0;
               end else begin
                  rank_in = rank_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Shift down everything from the insert point and drop the tail.
      if (do_insert) begin
         for (int k = 0; k < TOP_K; k++) begin
            if (beats_prev[k]) begin
               best_score_in[k] = best_score_ff[(k == 0) ? 0 : k - 1];
               best_index_in[k] = best_index_ff[(k == 0) ? 0 : k - 1];
            end else if (beats[k]) begin
               best_score_in[k] = cmd_head.score;
               best_index_in[k] = cmd_head.index;
            end
         end
         used_in = (used_ff << 1) | TOP_K'(1);
      end

      if (res_push) begin
         outq_in[outq_wr_ff] = res;
         outq_wr_in = outq_wr_ff + 1'b1;
      end
      if (res_pop) begin
         outq_rd_in = outq_rd_ff + 1'b1;
      end
      if (res_push && !res_pop) begin
         outq_cnt_in = outq_cnt_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         outq_cnt_in = outq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      best_score_ff <= best_score_in;
      best_index_ff <= best_index_in;
      outq_ff       <= outq_in;
      rank_ff       <= rank_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         used_ff     <= '0;
         outq_wr_ff  <= '0;
         outq_rd_ff  <= '0;
         outq_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         outq_wr_ff  <= outq_wr_in;
         outq_rd_ff  <= outq_rd_in;
         outq_cnt_ff <= outq_cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_used_prefix: assert property (@(posedge clock) disable iff (reset)
      ((used_ff & (used_ff + 1'b1)) == '0))
      else $error("used slots are not a prefix of the list");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.last) |=> ((state_ff == S_IDLE) && (used_ff == '0)))
      else $error("list not cleared after the last result");

   a_no_pop_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> !cmd_pop)
      else $error("command taken while emitting results");
`endif

endmodule
